// ===== design/ctp_pkg.sv =====
`default_nettype none
package ctp_pkg;

  localparam int TRIG_FRAC = 14;
  localparam int NUM_REGS  = 6;

  typedef enum logic [2:0] {
    REG_COS_PITCH = 3'd0,
    REG_SIN_PITCH = 3'd1,
    REG_COS_YAW   = 3'd2,
    REG_SIN_YAW   = 3'd3,
    REG_COS_ROLL  = 3'd4,
    REG_SIN_ROLL  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] camera_x;
    logic signed [31:0] camera_y;
    logic signed [31:0] camera_z;
  } req_t;

  typedef struct packed {
    logic signed [31:0] view_x;
    logic signed [31:0] view_y;
    logic signed [31:0] view_z;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic               in_front;
  } res_t;

  localparam logic signed [47:0] SAT_MAX = 48'sh0000_7FFF_FFFF;
  localparam logic signed [47:0] SAT_MIN = -48'sh0000_8000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/ctp_div.sv =====
`default_nettype none
module ctp_div #(
  parameter int NW = 49
) (
  input  wire logic          clk,
  input  wire logic [NW-1:0] num,
  input  wire logic [31:0]   den,
  output logic [NW-1:0]      quo
);
  import ctp_pkg::*;

  logic [31:0]   rem  [NW+1];
  logic [NW-1:0] nsh  [NW+1];
  logic [NW-1:0] qacc [NW+1];
  logic [31:0]   dpip [NW+1];

  assign rem[0]  = '0;
  assign nsh[0]  = num;
  assign qacc[0] = '0;
  assign dpip[0] = den;

  for (genvar k = 0; k < NW; k++) begin : g_step
    logic [32:0] trial;
    logic        ge;
    assign trial = {rem[k], nsh[k][NW-1]};
    assign ge    = trial >= {1'b0, dpip[k]};
    always_ff @(posedge clk) begin
      rem[k+1]  <= ge ? 32'(trial - {1'b0, dpip[k]}) : trial[31:0];
      nsh[k+1]  <= nsh[k] << 1;
      qacc[k+1] <= {qacc[k][NW-2:0], ge};
      dpip[k+1] <= dpip[k];
    end
  end

  assign quo = qacc[NW];

endmodule
`default_nettype wire

// ===== design/camera_transform_and_project_top.sv =====
`default_nettype none
// Camera transform and perspective projection.
// Request channel: drive the world point and camera position on request and
// raise start; busy is always low, so a request is taken at every edge where
// start is high, one per cycle.
// Result channel: each request yields one result on result, marked by done
// for one cycle. The receiver cannot stall; results are never held back.
// Throughput is one request per cycle: the offset and rotation run through
// seven register stages and the two projections through bit-serial dividers
// unrolled into one register stage per quotient bit.
// Configuration: six 16-bit Q2.14 sine/cosine registers on the APB port at
// byte addresses 0, 4, ... 20; write them only while no request is in flight.
// Reset: rst clears all valid bits, drops done and restores the registers to
// identity rotation (cosines 1.0, sines 0).
module camera_transform_and_project_top #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire ctp_pkg::req_t request,
  output logic               done,
  output ctp_pkg::res_t      result,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ctp_pkg::*;

  localparam int NW  = 33 + FRAC_BITS;
  localparam int LAT = 9 + NW;

  logic signed [15:0] cos_pitch, sin_pitch, cos_yaw, sin_yaw, cos_roll, sin_roll;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_pitch <= 16'sd16384;
      sin_pitch <= '0;
      cos_yaw   <= 16'sd16384;
      sin_yaw   <= '0;
      cos_roll  <= 16'sd16384;
      sin_roll  <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_t'(paddr[4:2]))
        REG_COS_PITCH: cos_pitch <= pwdata[15:0];
        REG_SIN_PITCH: sin_pitch <= pwdata[15:0];
        REG_COS_YAW:   cos_yaw   <= pwdata[15:0];
        REG_SIN_YAW:   sin_yaw   <= pwdata[15:0];
        REG_COS_ROLL:  cos_roll  <= pwdata[15:0];
        REG_SIN_ROLL:  sin_roll  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[4:2]))
      REG_COS_PITCH: prdata = {16'd0, cos_pitch};
      REG_SIN_PITCH: prdata = {16'd0, sin_pitch};
      REG_COS_YAW:   prdata = {16'd0, cos_yaw};
      REG_SIN_YAW:   prdata = {16'd0, sin_yaw};
      REG_COS_ROLL:  prdata = {16'd0, cos_roll};
      REG_SIN_ROLL:  prdata = {16'd0, sin_roll};
      default:       prdata = '0;
    endcase
  end

  logic [8:1] v;

  // stage 1: offsets
  logic signed [32:0] dx, dy, dz;
  // stage 2: first rotation products
  logic signed [34:0] qa, qb, qc, qd, qe, qf;
  // stage 3
  logic signed [35:0] a3, b3;
  logic signed [34:0] qe3, qf3;
  // stage 4
  logic signed [37:0] qsa, qca;
  logic signed [35:0] b4;
  logic signed [34:0] qe4, qf4;
  // stage 5
  logic signed [38:0] c5;
  logic signed [35:0] b5;
  logic signed [31:0] vx5;
  // stage 6
  logic signed [40:0] qspc, qcpc;
  logic signed [37:0] qcpb, qspb;
  logic signed [31:0] vx6;
  // stage 7
  logic signed [31:0] vx7, vy7, vz7;
  // stage 8
  logic signed [31:0] vx8, vy8, vz8;
  logic [NW-1:0]      nx8, ny8;
  logic [31:0]        den8;

  logic signed [48:0] pa, pb, pc, pd, pe, pf;
  logic signed [51:0] psa, pca;
  logic signed [54:0] pspc, pcpc;
  logic signed [51:0] pcpb, pspb;
  logic [31:0]        ax7, ay7, az7;

  assign pa = 49'(sin_roll) * 49'(dy);
  assign pb = 49'(cos_roll) * 49'(dx);
  assign pc = 49'(cos_roll) * 49'(dy);
  assign pd = 49'(sin_roll) * 49'(dx);
  assign pe = 49'(cos_yaw) * 49'(dz);
  assign pf = 49'(sin_yaw) * 49'(dz);
  assign psa = 52'(sin_yaw) * 52'(a3);
  assign pca = 52'(cos_yaw) * 52'(a3);
  assign pspc = 55'(sin_pitch) * 55'(c5);
  assign pcpc = 55'(cos_pitch) * 55'(c5);
  assign pcpb = 52'(cos_pitch) * 52'(b5);
  assign pspb = 52'(sin_pitch) * 52'(b5);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[7:1], start};
    end
  end

  always_ff @(posedge clk) begin
    dx <= 33'(request.point_x) - 33'(request.camera_x);
    dy <= 33'(request.point_y) - 33'(request.camera_y);
    dz <= 33'(request.point_z) - 33'(request.camera_z);

    qa <= 35'((pa + 49'sd8192) >>> TRIG_FRAC);
    qb <= 35'((pb + 49'sd8192) >>> TRIG_FRAC);
    qc <= 35'((pc + 49'sd8192) >>> TRIG_FRAC);
    qd <= 35'((pd + 49'sd8192) >>> TRIG_FRAC);
    qe <= 35'((pe + 49'sd8192) >>> TRIG_FRAC);
    qf <= 35'((pf + 49'sd8192) >>> TRIG_FRAC);

    a3  <= 36'(qa) + 36'(qb);
    b3  <= 36'(qc) - 36'(qd);
    qe3 <= qe;
    qf3 <= qf;

    qsa <= 38'((psa + 52'sd8192) >>> TRIG_FRAC);
    qca <= 38'((pca + 52'sd8192) >>> TRIG_FRAC);
    b4  <= b3;
    qe4 <= qe3;
    qf4 <= qf3;

    c5  <= 39'(qe4) + 39'(qsa);
    vx5 <= sat32(48'(qca) - 48'(qf4));
    b5  <= b4;

    qspc <= 41'((pspc + 55'sd8192) >>> TRIG_FRAC);
    qcpc <= 41'((pcpc + 55'sd8192) >>> TRIG_FRAC);
    qcpb <= 38'((pcpb + 52'sd8192) >>> TRIG_FRAC);
    qspb <= 38'((pspb + 52'sd8192) >>> TRIG_FRAC);
    vx6  <= vx5;

    vx7 <= vx6;
    vy7 <= sat32(48'(qspc) + 48'(qcpb));
    vz7 <= sat32(48'(qcpc) - 48'(qspb));

    vx8  <= vx7;
    vy8  <= vy7;
    vz8  <= vz7;
    nx8  <= NW'(ax7) << (FRAC_BITS + 1);
    ny8  <= NW'(ay7) << (FRAC_BITS + 1);
    den8 <= az7;
  end

  assign ax7 = vx7[31] ? -vx7 : vx7;
  assign ay7 = vy7[31] ? -vy7 : vy7;
  assign az7 = vz7[31] ? -vz7 : vz7;

  logic [NW-1:0] qx, qy;

  ctp_div #(.NW(NW)) u_div_x (.clk(clk), .num(nx8), .den(den8), .quo(qx));
  ctp_div #(.NW(NW)) u_div_y (.clk(clk), .num(ny8), .den(den8), .quo(qy));

  logic               dv  [1:NW];
  logic signed [31:0] dlx [1:NW];
  logic signed [31:0] dly [1:NW];
  logic signed [31:0] dlz [1:NW];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 1; j <= NW; j++) dv[j] <= 1'b0;
    end else begin
      dv[1] <= v[8];
      for (int j = 2; j <= NW; j++) dv[j] <= dv[j-1];
    end
  end

  always_ff @(posedge clk) begin
    dlx[1] <= vx8;
    dly[1] <= vy8;
    dlz[1] <= vz8;
    for (int j = 2; j <= NW; j++) begin
      dlx[j] <= dlx[j-1];
      dly[j] <= dly[j-1];
      dlz[j] <= dlz[j-1];
    end
  end

  function automatic logic signed [31:0] fix_quo(input logic [NW-1:0] mag, input logic neg);
    logic signed [31:0] r;
    if (!neg && mag > NW'(32'h7FFF_FFFF)) begin
      r = 32'sh7FFF_FFFF;
    end else if (neg && mag > NW'(33'h0_8000_0000)) begin
      r = 32'sh8000_0000;
    end else if (neg) begin
      r = -mag[31:0];
    end else begin
      r = mag[31:0];
    end
    return r;
  endfunction

  logic zero_z;
  assign zero_z = dlz[NW] == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv[NW];
    end
  end

  always_ff @(posedge clk) begin
    result.view_x   <= dlx[NW];
    result.view_y   <= dly[NW];
    result.view_z   <= dlz[NW];
    result.screen_x <= zero_z ? '0 : fix_quo(qx, dlx[NW][31] ^ dlz[NW][31]);
    result.screen_y <= zero_z ? '0 : fix_quo(qy, dly[NW][31] ^ dlz[NW][31]);
    result.in_front <= !dlz[NW][31];
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##(LAT) done) else $error("request lost in pipeline");

  a_front: assert property (@(posedge clk) disable iff (rst)
    done |-> result.in_front == !result.view_z[31]) else $error("in_front mismatch");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.view_z == 32'sd0 |-> result.screen_x == 32'sd0 && result.screen_y == 32'sd0)
    else $error("nonzero projection at zero depth");

endmodule
`default_nettype wire

// ===== bench/tb_camera_transform_and_project_top.sv =====
`timescale 1ns / 1ps
module tb_camera_transform_and_project_top;
  import ctp_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam int LATENCY = 9 + 33 + FRAC_BITS;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  req_t request = '0;
  logic done;
  res_t result;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  camera_transform_and_project_top #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  logic signed [15:0] trig [NUM_REGS];
  req_t pending_requests[$];
  res_t expected_points[$];
  int errors = 0;
  int n_requests = 0, n_points = 0, n_behind = 0, n_zero_depth = 0;
  int idle_cycles = 0;
  int gap = 0;

  function automatic logic signed [63:0] rescale(logic signed [15:0] c,
                                                 logic signed [63:0] v);
    logic signed [63:0] p;
    p = c * v + 64'sd8192;
    return p >>> TRIG_FRAC;
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -64'sh8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic res_t project_point(req_t p);
    res_t r;
    logic signed [63:0] dx, dy, dz, a, b, c, vx, vy, vz;
    dx = 64'(p.point_x) - 64'(p.camera_x);
    dy = 64'(p.point_y) - 64'(p.camera_y);
    dz = 64'(p.point_z) - 64'(p.camera_z);
    a = rescale(trig[REG_SIN_ROLL], dy) + rescale(trig[REG_COS_ROLL], dx);
    b = rescale(trig[REG_COS_ROLL], dy) - rescale(trig[REG_SIN_ROLL], dx);
    c = rescale(trig[REG_COS_YAW], dz) + rescale(trig[REG_SIN_YAW], a);
    vx = clamp32(rescale(trig[REG_COS_YAW], a) - rescale(trig[REG_SIN_YAW], dz));
    vy = clamp32(rescale(trig[REG_SIN_PITCH], c) + rescale(trig[REG_COS_PITCH], b));
    vz = clamp32(rescale(trig[REG_COS_PITCH], c) - rescale(trig[REG_SIN_PITCH], b));
    r.view_x = vx[31:0];
    r.view_y = vy[31:0];
    r.view_z = vz[31:0];
    r.screen_x = '0;
    r.screen_y = '0;
    if (vz != 0) begin
      r.screen_x = clamp32((vx <<< (FRAC_BITS + 1)) / vz);
      r.screen_y = clamp32((vy <<< (FRAC_BITS + 1)) / vz);
    end
    r.in_front = (vz >= 0);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 0;
      gap <= 0;
    end else begin
      if (start && !busy) begin
        expected_points.push_back(project_point(request));
        n_requests <= n_requests + 1;
      end
      if (start && busy) begin
      end else if (gap > 0) begin
        gap <= gap - 1;
        start <= 0;
      end else if (pending_requests.size() > 0) begin
        request <= pending_requests.pop_front();
        start <= 1;
        if ($urandom_range(0, 99) < 25)
          gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
      end else begin
        start <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        errors++;
      end else begin
        res_t e;
        e = expected_points.pop_front();
        if (e.view_x !== result.view_x || e.view_y !== result.view_y ||
            e.view_z !== result.view_z || e.screen_x !== result.screen_x ||
            e.screen_y !== result.screen_y || e.in_front !== result.in_front) begin
          $display("%0t: mismatch expected vx=%h vy=%h vz=%h sx=%h sy=%h f=%b", $time,
                   e.view_x, e.view_y, e.view_z, e.screen_x, e.screen_y, e.in_front);
          $display("%0t:          actual   vx=%h vy=%h vz=%h sx=%h sy=%h f=%b", $time,
                   result.view_x, result.view_y, result.view_z, result.screen_x,
                   result.screen_y, result.in_front);
          errors++;
        end
        n_points++;
        if (!e.in_front) n_behind++;
        if (e.view_z == 0) n_zero_depth++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_trig(reg_idx_t idx, logic [15:0] v);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= 5'(4 * int'(idx));
    pwdata <= {{16{v[15]}}, v};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    trig[idx] = v;
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic drain();
    while (pending_requests.size() > 0 || start || expected_points.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    logic [31:0] v;
    case (mode)
      0: v = $urandom;
      1: v = 32'($signed($urandom_range(0, 2000000)) - 1000000);
      2: v = 32'($signed($urandom_range(0, 40)) - 20) <<< 16;
      default: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
    return v;
  endfunction

  function automatic req_t rand_request();
    req_t r;
    int mode;
    mode = $urandom_range(0, 9);
    mode = (mode < 3) ? 0 : (mode < 6) ? 1 : (mode < 9) ? 2 : 3;
    r.point_x = rand_coord(mode);
    r.point_y = rand_coord(mode);
    r.point_z = rand_coord(mode);
    r.camera_x = rand_coord(mode);
    r.camera_y = rand_coord(mode);
    r.camera_z = rand_coord(mode);
    if ($urandom_range(0, 19) == 0) r.point_z = r.camera_z;
    return r;
  endfunction

  initial begin
    req_t r;
    trig[REG_COS_PITCH] = 16384; trig[REG_SIN_PITCH] = 0;
    trig[REG_COS_YAW] = 16384;   trig[REG_SIN_YAW] = 0;
    trig[REG_COS_ROLL] = 16384;  trig[REG_SIN_ROLL] = 0;
    repeat (7) @(posedge clk);
    rst <= 0;

    // directed: extremes, zero depth, behind camera
    r = '0;
    pending_requests.push_back(r);
    r.point_z = 32'sh0001_0000;
    r.point_x = 32'sh0003_0000;
    r.point_y = -32'sh0002_0000;
    pending_requests.push_back(r);
    r.point_z = -32'sh0001_0000;
    pending_requests.push_back(r);
    r = '0;
    r.point_x = 32'sh7FFF_FFFF; r.point_y = 32'sh7FFF_FFFF; r.point_z = 32'sh7FFF_FFFF;
    r.camera_x = 32'sh8000_0000; r.camera_y = 32'sh8000_0000; r.camera_z = 32'sh8000_0000;
    pending_requests.push_back(r);
    r = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
          32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
    pending_requests.push_back(r);
    r = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0001, 0, 0, 0};
    pending_requests.push_back(r);
    r = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -32'sh0000_0001, 0, 0, 0};
    pending_requests.push_back(r);
    r = '{32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF,
          32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF};
    pending_requests.push_back(r);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        logic [15:0] v;
        case (phase)
          0: v = (i % 2) ? 16'h0000 : 16'h4000;
          1: v = (i % 2) ? 16'h4000 : 16'h0000;
          2: v = 16'h8000;
          3: v = 16'h7FFF;
          4: v = (i % 2) ? 16'hC000 : 16'h4000;
          5: v = 16'($signed($urandom_range(0, 32768)) - 16384);
          6: v = $urandom;
          default: v = 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
        write_trig(reg_idx_t'(i), v);
      end
      for (int i = 0; i < ((phase == 7) ? 500 : 200); i++)
        pending_requests.push_back(rand_request());
      drain();
    end

    $display("Covered %0d requests over 8 trig settings: %0d results, %0d behind camera,",
             n_requests, n_points, n_behind);
    $display("%0d at zero depth.", n_zero_depth);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
